/* src/ctl_pkg.sv */
// Package for the cache tag lookup block: types and fixed constants.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps
package ctl_pkg;
    localparam int ADDR_W = 32;
    localparam int TAG_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_FOUR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ASSOC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINES   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET  = 3'd3;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_SHIFT = 6'b000100,
        ST_DONE  = 6'b001000,
        ST_WAIT  = 6'b010000,
        ST_CLEAR = 6'b100000
    } state_t;
endpackage

/* src/cache_tag_lookup_fifo_lru.sv */
// Top level of the cache tag lookup block with FIFO or LRU replacement.
// Depends on ctl_pkg.
`timescale 1ns / 1ps
// Usage:
//   Request channel: drive address and pulse start while busy is low; the
//   request is taken at that edge and busy rises at once.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. Index
//   0 assoc_mode, 1 replace_policy, 2 lines_log2, 3 offset_bits. A write to
//   a listed register also invalidates every line; other indexes are ignored.
//   Write only while busy is low.
//   Result: done is high for one cycle with evicted and victim_tag. The
//   receiver cannot stall; the result is simply shown for that cycle.
// Timing:
//   The tag memory has one write port and one registered read port. The
//   scan reads one way per cycle (pipelined) and ends at a hit, a free way
//   or the last way. An LRU hit before the last way and an eviction then
//   shift the queue, one entry per cycle. Fully associative mode has up to
//   256 ways.
// Reset:
//   Valid bits are flip-flops cleared at once; the tag memory is not cleared
//   and needs no clearing pass. Registers reset to direct mapped, FIFO,
//   lines_log2 8, offset_bits 4.
module cache_tag_lookup_fifo_lru
    import ctl_pkg::*;
#(
    parameter int MAX_LINES_LOG2 = 8
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ADDR_W-1:0]    address,
    output logic                 done,
    output logic                 evicted,
    output logic [TAG_W-1:0]     victim_tag,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);
    localparam int DEPTH = 1 << MAX_LINES_LOG2;
    localparam int AW    = MAX_LINES_LOG2;
    localparam int CW    = AW + 1;

    // configuration
    logic [1:0] assoc_reg;
    logic       policy_reg;
    logic [3:0] lines_reg;
    logic [4:0] offset_reg;

    // tag memory and valid bits
    logic [TAG_W-1:0] mem [DEPTH];
    logic [TAG_W-1:0] rd_data;
    logic [DEPTH-1:0] valid_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [TAG_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;

    state_t state_reg, state_next;
    logic [TAG_W-1:0] tag_reg;
    logic [AW-1:0]    base_reg;
    logic [CW-1:0]    ways_reg;
    logic [CW-1:0]    rd_cnt_reg;   // next way to read
    logic [CW-1:0]    chk_cnt_reg;  // way whose data is on rd_data
    logic             chk_vld_reg;
    logic [CW-1:0]    shift_end_reg;
    logic             ev_reg;
    logic [TAG_W-1:0] vt_reg;

    // effective geometry
    logic [3:0]  eff_l;
    logic [3:0]  idx_bits;
    logic [CW-1:0] ways;
    logic [5:0]  shift;
    logic [31:0] set_val;
    logic [TAG_W-1:0] tag_val;
    logic [AW-1:0] base_val;

    always_comb
    begin
        eff_l = lines_reg;
        if (eff_l < 4'd2) eff_l = 4'd2;
        if (eff_l > 4'(MAX_LINES_LOG2)) eff_l = 4'(MAX_LINES_LOG2);
        case (assoc_reg)
            MODE_DIRECT:
            begin
                idx_bits = eff_l;
                ways = CW'(1);
            end
            MODE_FOUR:
            begin
                idx_bits = eff_l - 4'd2;
                ways = CW'(4);
            end
            default:
            begin
                idx_bits = 4'd0;
                ways = CW'(1) << eff_l;
            end
        endcase
        set_val  = (address >> offset_reg) & ((32'd1 << idx_bits) - 32'd1);
        shift    = 6'(offset_reg) + 6'(idx_bits);
        tag_val  = (shift >= 6'd32) ? '0 : (address >> shift);
        // set * ways: ways is a power of two, so shift the set
        case (assoc_reg)
            MODE_DIRECT: base_val = AW'(set_val);
            MODE_FOUR:   base_val = AW'(set_val << 2);
            default:     base_val = '0;
        endcase
    end

    wire accept  = start && !busy;
    wire cfg_hit = cfg_valid && cfg_ready && (cfg_index <= 3'(REG_OFFSET));
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assoc_reg  <= MODE_DIRECT;
            policy_reg <= 1'b0;
            lines_reg  <= 4'd8;
            offset_reg <= 5'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                3'(REG_ASSOC):  assoc_reg  <= cfg_data[1:0];
                3'(REG_POLICY): policy_reg <= cfg_data[0];
                3'(REG_LINES):  lines_reg  <= cfg_data[3:0];
                3'(REG_OFFSET): offset_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data <= mem[mem_raddr];
    end

    wire [AW-1:0] chk_addr = base_reg + AW'(chk_cnt_reg);
    wire          chk_valid = valid_reg[chk_addr];
    wire          chk_last  = (chk_cnt_reg + CW'(1) == ways_reg);
    // during shift, chk_cnt is the source way j+1 whose data arrives now
    wire          src_valid = valid_reg[chk_addr];

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = chk_addr;
        mem_wdata  = rd_data;
        mem_raddr  = base_reg + AW'(rd_cnt_reg);
        case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = base_val;
                if (accept)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (chk_vld_reg)
                begin
                    if (!chk_valid)
                    begin
                        mem_we = 1'b1;
                        mem_wdata = tag_reg;
                        state_next = ST_DONE;
                    end
                    else if (rd_data == tag_reg)
                    begin
                        if (policy_reg && !chk_last)
                            state_next = ST_SHIFT;
                        else
                            state_next = ST_DONE;
                    end
                    else if (chk_last)
                        state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // chk_cnt is the source way; copy to way chk_cnt-1
                if (chk_vld_reg)
                begin
                    mem_we = 1'b1;
                    mem_waddr = chk_addr - AW'(1);
                    if (chk_cnt_reg == shift_end_reg || !src_valid)
                    begin
                        mem_wdata = tag_reg;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            chk_vld_reg <= 1'b0;
            ev_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_hit)
                valid_reg <= '0;
            if (state_reg == ST_SCAN && chk_vld_reg && !chk_valid)
                valid_reg[chk_addr] <= 1'b1;
            case (state_reg)
                ST_IDLE:
                begin
                    chk_vld_reg <= accept;
                    ev_reg      <= 1'b0;
                end
                ST_SCAN:
                begin
                    if (state_next == ST_SHIFT)
                    begin
                        // restart the read stream at the way after the start
                        if (chk_vld_reg && chk_valid && rd_data == tag_reg)
                        begin
                            chk_vld_reg <= 1'b0;
                        end
                        else
                        begin
                            ev_reg      <= 1'b1;
                            chk_vld_reg <= 1'b0;
                        end
                    end
                    else if (state_next == ST_SCAN)
                        chk_vld_reg <= (rd_cnt_reg < ways_reg);
                    else
                        chk_vld_reg <= 1'b0;
                end
                ST_SHIFT:
                begin
                    chk_vld_reg <= 1'b1;
                    if (state_next != ST_SHIFT)
                        chk_vld_reg <= 1'b0;
                end
                default: chk_vld_reg <= 1'b0;
            endcase
        end
    end

    // payload and counters
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                tag_reg     <= tag_val;
                base_reg    <= base_val;
                ways_reg    <= ways;
                rd_cnt_reg  <= CW'(1);
                chk_cnt_reg <= '0;
                // a source one past the last way ends the shift
                shift_end_reg <= ways;
                vt_reg      <= '0;
            end
            ST_SCAN:
            begin
                if (state_next == ST_SHIFT)
                begin
                    if (chk_vld_reg && chk_valid && rd_data == tag_reg)
                    begin
                        chk_cnt_reg <= chk_cnt_reg + CW'(1);
                        rd_cnt_reg  <= chk_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        chk_cnt_reg <= CW'(1);
                        rd_cnt_reg  <= CW'(1);
                    end
                end
                else
                begin
                    if (chk_vld_reg)
                        chk_cnt_reg <= chk_cnt_reg + CW'(1);
                    rd_cnt_reg <= rd_cnt_reg + CW'(1);
                end
                // oldest way's tag, captured when way 0 is checked
                if (chk_vld_reg && chk_cnt_reg == '0)
                    vt_reg <= rd_data;
            end
            ST_SHIFT:
            begin
                // first cycle: issue the read of the first source way
                if (chk_vld_reg)
                begin
                    chk_cnt_reg <= chk_cnt_reg + CW'(1);
                    rd_cnt_reg  <= rd_cnt_reg + CW'(1);
                end
                else
                    rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            default: ;
        endcase
    end

    // the read of the first shift source is issued in the first SHIFT cycle,
    // from rd_cnt, which the SCAN->SHIFT transition sets to that source way.
    // With one way the queue end is reached on the first copy.

    assign done       = (state_reg == ST_DONE);
    assign evicted    = ev_reg;
    assign victim_tag = ev_reg ? vt_reg : '0;
endmodule

/* src/ctl_checker.sv */
// Port-level checker for the cache tag lookup block, with its bind.
// Depends on ctl_pkg and the top level cache_tag_lookup_fifo_lru.
`timescale 1ns / 1ps
module ctl_checker
    import ctl_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic             evicted,
    input logic [TAG_W-1:0] victim_tag,
    input logic             cfg_ready
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("request not taken");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result longer than a cycle");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result outside a request");
    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !evicted |-> victim_tag == '0) else $error("stray victim");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy) else $error("config open while busy");
endmodule

bind cache_tag_lookup_fifo_lru ctl_checker u_ctl_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .evicted(evicted), .victim_tag(victim_tag), .cfg_ready(cfg_ready)
);

/* test/testbench.sv */
// Testbench for cache_tag_lookup_fifo_lru: directed and random requests
// checked against an in-bench model of the FIFO/LRU tag store.
// Depends on ctl_pkg and the cache_tag_lookup_fifo_lru top level.
`timescale 1ns / 1ps
module testbench
    import ctl_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam int STORE_DEPTH = 256;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic        evicted;
        logic [31:0] victim;
    } lookup_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [ADDR_W-1:0]    address;
    logic                 done;
    logic                 evicted;
    logic [TAG_W-1:0]     victim_tag;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // Shadow of the block: tag queues, valid bits and register values.
    logic [31:0] tag_mem [STORE_DEPTH];
    bit          line_vld [STORE_DEPTH];
    logic [1:0]  assoc_mode;
    logic        lru_mode;
    logic [3:0]  lines_log2;
    logic [4:0]  offset_bits;

    lookup_t     pending_lookups [$];
    logic [31:0] addr_pool [24];
    int          errors;
    int          results_seen;
    int          evictions_seen;
    int          requests_sent;
    int          cycles;
    bit          idle_enable;

    cache_tag_lookup_fifo_lru uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .address    (address),
        .done       (done),
        .evicted    (evicted),
        .victim_tag (victim_tag),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Walk the set's queue the way the block does and return the outcome.
    function automatic lookup_t predict_lookup(input logic [31:0] a);
        lookup_t     r;
        int unsigned l, ib, ways, sh, set_no, base, i, j;
        logic [31:0] tg;
        r = '0;
        l = 32'(lines_log2);
        if (l < 2) l = 2;
        if (l > 8) l = 8;
        case (assoc_mode)
            MODE_DIRECT:
            begin
                ib = l;
                ways = 1;
            end
            MODE_FOUR:
            begin
                ib = l - 2;
                ways = 4;
            end
            default:
            begin
                ib = 0;
                ways = 1 << l;
            end
        endcase
        set_no = (a >> offset_bits) & ((32'd1 << ib) - 32'd1);
        sh = 32'(offset_bits) + ib;
        tg = (sh >= 32) ? 32'd0 : (a >> sh);
        base = (set_no * ways) & (STORE_DEPTH - 1);
        for (i = 0; i < ways; i++)
        begin
            if (!line_vld[base + i])
            begin
                tag_mem[base + i] = tg;
                line_vld[base + i] = 1'b1;
                return r;
            end
            if (tag_mem[base + i] == tg)
            begin
                // LRU hit: slide the younger valid tags down, put this one last
                if (lru_mode)
                begin
                    j = i;
                    while (j + 1 < ways && line_vld[base + j + 1])
                    begin
                        tag_mem[base + j] = tag_mem[base + j + 1];
                        j++;
                    end
                    tag_mem[base + j] = tg;
                end
                return r;
            end
        end
        // full set, no match: drop the oldest, append the new tag
        r.evicted = 1'b1;
        r.victim = tag_mem[base];
        for (i = 0; i + 1 < ways; i++)
            tag_mem[base + i] = tag_mem[base + i + 1];
        tag_mem[base + ways - 1] = tg;
        return r;
    endfunction

    // Optional idle burst on the request side.
    task automatic maybe_idle();
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Send one request; start stays high after acceptance so back-to-back
    // requests never lower and raise it in the same step.
    task automatic send_request(input logic [31:0] a);
        bit taken;
        maybe_idle();
        start <= 1'b1;
        address <= a;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        pending_lookups.push_back(predict_lookup(a));
        requests_sent++;
    endtask

    // Hold until every result is back and the block reports idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_lookups.size() != 0) @(posedge clk);
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        bit taken;
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        // unlisted indexes change nothing, listed ones flush every line
        if (idx <= REG_OFFSET)
        begin
            case (idx)
                REG_ASSOC:  assoc_mode = val[1:0];
                REG_POLICY: lru_mode = val[0];
                REG_LINES:  lines_log2 = val[3:0];
                default:    offset_bits = val[4:0];
            endcase
            for (int i = 0; i < STORE_DEPTH; i++) line_vld[i] = 1'b0;
        end
    endtask

    task automatic set_geometry(input logic [1:0] m, input logic p,
                                input logic [3:0] l, input logic [4:0] o);
        write_reg(REG_ASSOC, {$urandom} & 32'hFFFF_FFFC | 32'(m));
        write_reg(REG_POLICY, {$urandom} & 32'hFFFF_FFFE | 32'(p));
        write_reg(REG_LINES, {$urandom} & 32'hFFFF_FFF0 | 32'(l));
        write_reg(REG_OFFSET, {$urandom} & 32'hFFFF_FFE0 | 32'(o));
    endtask

    // Check each result in the cycle it is shown; sample mid-cycle.
    always @(negedge clk)
    begin
        lookup_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (evicted === 1'b1) evictions_seen++;
            if (pending_lookups.size() == 0)
                report("result with no request outstanding");
            else
            begin
                want = pending_lookups.pop_front();
                if (evicted !== want.evicted)
                    report($sformatf("evicted %b, want %b", evicted, want.evicted));
                if (victim_tag !== want.victim)
                    report($sformatf("victim_tag %h, want %h", victim_tag, want.victim));
            end
        end
    end

    // Reset defaults: direct mapped, 256 lines, 16-byte blocks.
    task automatic test_reset_defaults();
        send_request(32'h0000_0000);
        send_request(32'h0000_000F);          // same line, hit
        send_request(32'h0000_1000);          // same set, new tag: evict
        send_request(32'hFFFF_FFFF);          // all-ones tag fill
        send_request(32'hFFFF_FFF0);          // all-ones tag hit
        send_request(32'h0000_1FF0);          // evicts the all-ones tag
    endtask

    // Four-way LRU: refresh the oldest way so the second oldest goes out.
    task automatic test_four_way_lru();
        set_geometry(MODE_FOUR, 1'b1, 4'd2, 5'd0);
        for (int i = 0; i < 4; i++) send_request(32'h10 * i);
        send_request(32'h0);
        send_request(32'h40);
        send_request(32'h30);
        write_reg(REG_POLICY, 32'd0);         // FIFO: hit keeps the order
        for (int i = 0; i < 5; i++) send_request(32'h100 * (i % 3 + 1) + i[1:0] * 32'h100);
    endtask

    // Register corners: saturating line count, huge offset, unused mode and
    // an unlisted register index.
    task automatic test_register_corners();
        set_geometry(2'd3, 1'b1, 4'd15, 5'd31);
        send_request(32'h8000_0000);          // only the top bit is left as tag
        send_request(32'h7FFF_FFFF);          // tag 0 fills a second way
        set_geometry(MODE_DIRECT, 1'b0, 4'd0, 5'd29);
        send_request(32'hE000_0000);
        send_request(32'h2000_0000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF); // ignored, lines stay valid
        send_request(32'hE000_0000);
    endtask

    // Random phases: fresh geometry, then mostly reuse of a small address
    // pool so hits, refreshes and evictions all occur.
    task automatic test_random_traffic(input int phases, input int per_phase);
        logic [3:0]  l;
        logic [31:0] a;
        for (int p = 0; p < phases; p++)
        begin
            l = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(6, 15))
                                            : 4'($urandom_range(0, 5));
            set_geometry(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), l,
                         5'($urandom_range(0, 31)));
            foreach (addr_pool[i]) addr_pool[i] = $urandom;
            for (int n = 0; n < per_phase; n++)
            begin
                a = ($urandom_range(0, 4) == 0) ? $urandom
                                                : addr_pool[$urandom_range(0, 23)];
                send_request(a);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        address = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        results_seen = 0;
        evictions_seen = 0;
        requests_sent = 0;
        cycles = 0;
        idle_enable = 1'b1;
        assoc_mode = MODE_DIRECT;
        lru_mode = 1'b0;
        lines_log2 = 4'd8;
        offset_bits = 5'd4;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            tag_mem[i] = '0;
            line_vld[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_four_way_lru();
        test_register_corners();
        test_random_traffic(21, 50);
        idle_enable = 1'b0;                   // last stretch runs back to back
        test_random_traffic(2, 50);

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d requests, %0d results, %0d evictions",
                 requests_sent, results_seen, evictions_seen);
        $display("direct, four-way and fully associative; FIFO and LRU");
        if (errors == 0 && pending_lookups.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
